### rtl/core/sdo_client_upload_engine_macros.svh
// Assertion macros used by the upload engine back sequencer (sdo_back).
`ifndef SDO_CLIENT_UPLOAD_ENGINE_MACROS_SVH
`define SDO_CLIENT_UPLOAD_ENGINE_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define SDO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after another one holds.
`define SDO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sdo_pkg.sv
package sdo_pkg;

    // Phases of one upload.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_INIT  = 3'd1;
    localparam logic [2:0] PH_SEG   = 3'd2;
    localparam logic [2:0] PH_BINIT = 3'd3;
    localparam logic [2:0] PH_BDATA = 3'd4;
    localparam logic [2:0] PH_BEND  = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Final status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ABORT    = 2'd1;
    localparam logic [1:0] ST_PROTOCOL = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INDEX    = 2'd0;
    localparam logic [1:0] CFG_SUBINDEX = 2'd1;
    localparam logic [1:0] CFG_BLKMODE  = 2'd2;
    localparam logic [1:0] CFG_BLKSIZE  = 2'd3;

    localparam logic [31:0] ABORT_LEN_MISMATCH = 32'h0607_0010;
    localparam logic [7:0]  CMD_ABORT          = 8'h80;
    localparam logic [6:0]  MAX_BLOCK          = 7'd127;

    // One classified command from the front part to the back part.
    // A sequence of up to two frames, up to seven payload bytes and an optional status.
    typedef struct packed {
        logic        frame0_en;
        logic [63:0] frame0;
        logic [3:0]  nbytes;
        logic [55:0] bytes;
        logic        frame1_en;
        logic [63:0] frame1;
        logic        status_en;
        logic [1:0]  status;
        logic [31:0] count;
    } t_cmd;

endpackage

### rtl/core/sdo_front.sv
module sdo_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_func,
    input  logic [63:0]      i_rx_frame,
    input  logic [31:0]      i_capacity,
    input  logic [15:0]      i_object_index,
    input  logic [7:0]       i_object_subindex,
    input  logic             i_block_mode,
    input  logic [6:0]       i_block_size,
    output logic             o_cmd_valid,
    output sdo_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_full
);

    logic [2:0]  r_phase;
    logic        r_toggle;
    logic [31:0] r_total;
    logic [31:0] r_count;
    logic [6:0]  r_seq;
    logic [6:0]  r_req;
    logic [31:0] r_cap;

    logic [2:0]  n_phase;
    logic        n_toggle;
    logic [31:0] n_total;
    logic [31:0] n_count;
    logic [6:0]  n_seq;
    logic [6:0]  n_req;
    logic [31:0] n_cap;
    sdo_pkg::t_cmd n_cmd;
    logic        n_any;

    logic        acc;
    logic [7:0]  b0;
    logic [2:0]  scs;
    logic [63:0] idx_bytes;
    logic [63:0] abort_frame;
    logic [31:0] hi;
    logic [31:0] room;
    logic [3:0]  take;
    logic [2:0]  exp_len;
    logic [31:0] cnt_after;
    logic [6:0]  req_new;

    assign o_in_stall = i_cmd_full;
    assign acc        = i_in_valid && !i_cmd_full;
    assign b0         = i_rx_frame[7:0];
    assign scs        = b0[7:5];
    assign hi         = i_rx_frame[63:32];
    assign idx_bytes  = {32'd0, i_object_subindex, i_object_index, 8'd0};
    assign abort_frame = {sdo_pkg::ABORT_LEN_MISMATCH, i_rx_frame[31:8], sdo_pkg::CMD_ABORT};
    assign room       = r_total - r_count;
    assign exp_len    = b0[0] ? (3'd4 - {1'b0, b0[3:2]}) : 3'd4;
    assign req_new    = (i_block_size == 7'd0) ? sdo_pkg::MAX_BLOCK : i_block_size;

    // Number of segment bytes kept, limited by the remaining announced size.
    always_comb begin
        logic [3:0] want;
        want = (r_phase == sdo_pkg::PH_BDATA) ? 4'd7 : (4'd7 - {1'b0, b0[3:1]});
        take = (room < {28'd0, want}) ? room[3:0] : want;
    end
    assign cnt_after = r_count + {28'd0, take};

    // Classify one input item into the results it causes.
    always_comb begin
        n_phase  = r_phase;
        n_toggle = r_toggle;
        n_total  = r_total;
        n_count  = r_count;
        n_seq    = r_seq;
        n_req    = r_req;
        n_cap    = r_cap;
        n_cmd    = '0;
        if (!i_func) begin
            n_cap    = i_capacity;
            n_total  = '0;
            n_count  = '0;
            n_toggle = 1'b0;
            n_seq    = 7'd1;
            n_cmd.frame0_en = 1'b1;
            if (i_block_mode) begin
                n_req   = req_new;
                n_phase = sdo_pkg::PH_BINIT;
                n_cmd.frame0 = 64'hA0 | idx_bytes | ({57'd0, req_new} << 32);
            end else begin
                n_phase = sdo_pkg::PH_INIT;
                n_cmd.frame0 = 64'h40 | idx_bytes;
            end
        end else begin
            unique case (r_phase)
                sdo_pkg::PH_INIT, sdo_pkg::PH_BINIT: begin
                    n_cmd.status_en = 1'b1;
                    n_cmd.status    = sdo_pkg::ST_PROTOCOL;
                    if (b0 == sdo_pkg::CMD_ABORT) begin
                        n_cmd.status = sdo_pkg::ST_ABORT;
                        n_phase = sdo_pkg::PH_IDLE;
                    end else if (scs == 3'd2) begin
                        // Initiate upload response, also the fallback from block mode.
                        n_count = '0;
                        n_cmd.count = '0;
                        n_phase = sdo_pkg::PH_IDLE;
                        if (b0[1]) begin
                            if ({29'd0, exp_len} > r_cap) begin
                                n_cmd.status = sdo_pkg::ST_OVERFLOW;
                            end else begin
                                n_cmd.nbytes = {1'b0, exp_len};
                                n_cmd.bytes  = {24'd0, hi};
                                n_cmd.status = sdo_pkg::ST_OK;
                                n_cmd.count  = {29'd0, exp_len};
                                n_count      = {29'd0, exp_len};
                            end
                        end else if (b0[0] && hi != 32'd0) begin
                            n_total = hi;
                            if (hi > r_cap) begin
                                n_cmd.frame0_en = 1'b1;
                                n_cmd.frame0    = abort_frame;
                                n_cmd.status    = sdo_pkg::ST_OVERFLOW;
                            end else begin
                                n_cmd.status_en = 1'b0;
                                n_cmd.frame0_en = 1'b1;
                                n_cmd.frame0    = 64'h60;
                                n_toggle = 1'b0;
                                n_phase  = sdo_pkg::PH_SEG;
                            end
                        end
                    end else if (r_phase == sdo_pkg::PH_BINIT && scs == 3'd6 && b0[1]) begin
                        n_total = hi;
                        n_count = '0;
                        n_phase = sdo_pkg::PH_IDLE;
                        n_cmd.count = '0;
                        if (hi == 32'd0) begin
                            n_cmd.status = sdo_pkg::ST_PROTOCOL;
                        end else if (hi > r_cap) begin
                            n_cmd.frame0_en = 1'b1;
                            n_cmd.frame0    = abort_frame;
                            n_cmd.status    = sdo_pkg::ST_OVERFLOW;
                        end else begin
                            n_cmd.status_en = 1'b0;
                            n_cmd.frame0_en = 1'b1;
                            n_cmd.frame0    = 64'hA3;
                            n_seq   = 7'd1;
                            n_phase = sdo_pkg::PH_BDATA;
                        end
                    end else begin
                        n_cmd.count = r_count;
                        n_phase = sdo_pkg::PH_IDLE;
                    end
                end
                sdo_pkg::PH_SEG: begin
                    n_cmd.count = r_count;
                    if (b0 == sdo_pkg::CMD_ABORT) begin
                        n_cmd.status_en = 1'b1;
                        n_cmd.status    = sdo_pkg::ST_ABORT;
                        n_phase = sdo_pkg::PH_IDLE;
                    end else if (scs != 3'd0 || b0[4] != r_toggle) begin
                        n_cmd.status_en = 1'b1;
                        n_cmd.status    = sdo_pkg::ST_PROTOCOL;
                        n_phase = sdo_pkg::PH_IDLE;
                    end else begin
                        n_cmd.nbytes = take;
                        n_cmd.bytes  = i_rx_frame[63:8];
                        n_count      = cnt_after;
                        n_cmd.count  = cnt_after;
                        n_toggle     = !r_toggle;
                        if (b0[0] && cnt_after < r_total) begin
                            n_cmd.status_en = 1'b1;
                            n_cmd.status    = sdo_pkg::ST_PROTOCOL;
                            n_phase = sdo_pkg::PH_IDLE;
                        end else if (cnt_after >= r_total) begin
                            n_cmd.status_en = 1'b1;
                            n_cmd.status    = sdo_pkg::ST_OK;
                            n_phase = sdo_pkg::PH_IDLE;
                        end else begin
                            n_cmd.frame1_en = 1'b1;
                            n_cmd.frame1    = 64'h60 | {59'd0, !r_toggle, 4'd0};
                        end
                    end
                end
                sdo_pkg::PH_BDATA: begin
                    n_cmd.count = r_count;
                    if (b0[6:0] != r_seq) begin
                        n_cmd.status_en = 1'b1;
                        n_cmd.status    = sdo_pkg::ST_PROTOCOL;
                        n_phase = sdo_pkg::PH_IDLE;
                    end else begin
                        n_cmd.nbytes = take;
                        n_cmd.bytes  = i_rx_frame[63:8];
                        n_count      = cnt_after;
                        n_cmd.frame1 = {40'd0, 1'b0, r_req, 1'b0, r_seq, 8'hA2};
                        if (cnt_after >= r_total) begin
                            n_cmd.frame1_en = 1'b1;
                            n_phase = sdo_pkg::PH_BEND;
                        end else if (r_seq >= r_req) begin
                            n_cmd.frame1_en = 1'b1;
                            n_seq = 7'd1;
                        end else begin
                            n_seq = r_seq + 7'd1;
                        end
                    end
                end
                sdo_pkg::PH_BEND: begin
                    n_cmd.count     = r_count;
                    n_cmd.status_en = 1'b1;
                    n_phase = sdo_pkg::PH_IDLE;
                    if (b0 == sdo_pkg::CMD_ABORT) begin
                        n_cmd.status = sdo_pkg::ST_ABORT;
                    end else if (scs != 3'd6 || b0[1:0] != 2'd1) begin
                        n_cmd.status = sdo_pkg::ST_PROTOCOL;
                    end else begin
                        n_cmd.frame0_en = 1'b1;
                        n_cmd.frame0    = 64'hA1;
                        n_cmd.status    = sdo_pkg::ST_OK;
                    end
                end
                default: begin
                    n_phase = sdo_pkg::PH_IDLE;
                end
            endcase
        end
        n_any = n_cmd.frame0_en || n_cmd.frame1_en || n_cmd.status_en
                || (n_cmd.nbytes != 4'd0);
    end

    // Phase state and the registered command toward the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sdo_pkg::PH_IDLE;
            r_toggle    <= 1'b0;
            r_total     <= '0;
            r_count     <= '0;
            r_seq       <= 7'd1;
            r_req       <= '0;
            r_cap       <= '0;
            o_cmd_valid <= 1'b0;
        end else begin
            o_cmd_valid <= acc && n_any;
            if (acc) begin
                r_phase  <= n_phase;
                r_toggle <= n_toggle;
                r_total  <= n_total;
                r_count  <= n_count;
                r_seq    <= n_seq;
                r_req    <= n_req;
                r_cap    <= n_cap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_cmd <= n_cmd;
    end

endmodule

### rtl/core/sdo_queue.sv
module sdo_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sdo_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    output sdo_pkg::t_cmd o_data,
    input  logic          i_pop
);

    localparam int AW = $clog2(DEPTH);

    sdo_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    // A slot is kept free for the command already in flight from the front part.
    assign o_full  = r_cnt >= (AW+1)'(DEPTH - 1);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop && o_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/core/sdo_back.sv
`include "sdo_client_upload_engine_macros.svh"

module sdo_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  sdo_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_kind,
    output logic [63:0]   o_tx_frame,
    output logic [7:0]    o_data_byte,
    output logic [1:0]    o_status,
    output logic [31:0]   o_byte_count,
    output logic          o_last
);

    // Step 0 first frame, steps 1..7 bytes, 8 second frame, 9 status.
    logic [3:0] r_step;
    logic [3:0] n_step;
    logic       have;
    logic       last_sel;
    logic       load;
    logic [2:0] bidx;

    // Pick the next step of the command that produces a result.
    always_comb begin
        n_step = 4'd10;
        if (r_step == 4'd0 && i_cmd.frame0_en) begin
            n_step = 4'd0;
        end else if (r_step <= 4'd7 && r_step < i_cmd.nbytes + 4'd1
                     && !(r_step == 4'd0 && i_cmd.nbytes == 4'd0)) begin
            n_step = (r_step == 4'd0) ? 4'd1 : r_step;
        end else if (r_step <= 4'd8 && i_cmd.frame1_en) begin
            n_step = 4'd8;
        end else if (i_cmd.status_en) begin
            n_step = 4'd9;
        end
    end

    assign have = i_cmd_valid && n_step != 4'd10;
    assign load = have && (!o_out_valid || !i_out_stall);
    assign bidx = 3'(n_step - 4'd1);

    // Last result of this command when no later step produces one.
    always_comb begin
        last_sel = 1'b1;
        unique case (n_step)
            4'd0:    last_sel = !(i_cmd.nbytes != 4'd0 || i_cmd.frame1_en || i_cmd.status_en);
            4'd8:    last_sel = !i_cmd.status_en;
            4'd9:    last_sel = 1'b1;
            default: last_sel = !(n_step < i_cmd.nbytes || i_cmd.frame1_en
                                  || i_cmd.status_en);
        endcase
    end

    assign o_cmd_pop = load && last_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (!o_out_valid || !i_out_stall) begin
                o_out_valid <= load;
            end
            if (load) begin
                r_step <= last_sel ? 4'd0 : n_step + 4'd1;
            end
        end
    end

    // Output register for the result payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_tx_frame   <= '0;
            o_data_byte  <= '0;
            o_status     <= '0;
            o_byte_count <= '0;
            o_last       <= last_sel;
            if (n_step == 4'd0) begin
                o_kind     <= sdo_pkg::KIND_FRAME;
                o_tx_frame <= i_cmd.frame0;
            end else if (n_step == 4'd8) begin
                o_kind     <= sdo_pkg::KIND_FRAME;
                o_tx_frame <= i_cmd.frame1;
            end else if (n_step == 4'd9) begin
                o_kind       <= sdo_pkg::KIND_STATUS;
                o_status     <= i_cmd.status;
                o_byte_count <= i_cmd.count;
            end else begin
                o_kind      <= sdo_pkg::KIND_BYTE;
                o_data_byte <= i_cmd.bytes[bidx*8 +: 8];
            end
        end
    end

    `SDO_ASSERT_IMP(a_pop_needs_valid, i_clk, i_rst_n, o_cmd_pop, i_cmd_valid,
        "command popped while queue empty")
    `SDO_ASSERT_NEXT(a_hold_when_stalled, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_kind) && $stable(o_last), "result changed under stall")
    `SDO_ASSERT_IMP(a_step_range, i_clk, i_rst_n, 1'b1, r_step <= 4'd9,
        "sequencer step out of range")

endmodule

### rtl/core/sdo_client_upload_engine.sv
// SDO client upload engine.
// Input channel (i_in_valid / o_in_stall) takes start items (i_func = 0) and
// received peer frames (i_func = 1). Results leave on the output channel
// (o_out_valid / i_out_stall), one per cycle unless stalled, o_last marking
// the final one of each input item. Configuration writes use i_cfg_valid /
// o_cfg_ready, always ready, and must happen only while the engine is idle.
// A front part tracks the upload phase and classifies each item into a
// registered command; a four-entry command queue feeds a back sequencer that
// emits up to ten results per command. The first result of an item passes
// the front command register, the queue and the output register before it
// is presented. One input item may be accepted every cycle while the queue
// is not full; the sustained rate is set by the back sequencer at one result
// per cycle while the receiver does not stall. A stalled receiver holds the
// current result; the queue then fills and the input is stalled. Reset
// clears the phase to idle and empties the queue.
module sdo_client_upload_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [63:0] i_rx_frame,
    input  logic [31:0] i_capacity,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [63:0] o_tx_frame,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_status,
    output logic [31:0] o_byte_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [15:0] r_object_index;
    logic [7:0]  r_object_subindex;
    logic        r_block_mode;
    logic [6:0]  r_block_size;

    logic          cmd_valid;
    sdo_pkg::t_cmd cmd;
    logic          q_full;
    logic          q_valid;
    sdo_pkg::t_cmd q_data;
    logic          q_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_object_index    <= '0;
            r_object_subindex <= '0;
            r_block_mode      <= 1'b0;
            r_block_size      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sdo_pkg::CFG_INDEX:    r_object_index    <= i_cfg_data[15:0];
                sdo_pkg::CFG_SUBINDEX: r_object_subindex <= i_cfg_data[7:0];
                sdo_pkg::CFG_BLKMODE:  r_block_mode      <= i_cfg_data[0];
                sdo_pkg::CFG_BLKSIZE:  r_block_size      <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    sdo_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_rx_frame        (i_rx_frame),
        .i_capacity        (i_capacity),
        .i_object_index    (r_object_index),
        .i_object_subindex (r_object_subindex),
        .i_block_mode      (r_block_mode),
        .i_block_size      (r_block_size),
        .o_cmd_valid       (cmd_valid),
        .o_cmd             (cmd),
        .i_cmd_full        (q_full)
    );

    sdo_queue #(.DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    sdo_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_data),
        .o_cmd_pop    (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_tx_frame   (o_tx_frame),
        .o_data_byte  (o_data_byte),
        .o_status     (o_status),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

endmodule
